// ===== rtl/lut3d_pkg.sv =====
// ----------------------------------------------------------------------------
// lut3d_pkg: shared constants, types and functions
// Sizes, payload types and the per-axis corner/fraction math for the
// color-cube interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package lut3d_pkg;

    localparam int MAX_GRID   = 17;
    localparam int CELLS      = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW         = $clog2(CELLS);
    localparam int CW         = 11;
    localparam int GW         = 5;
    localparam int FW         = 10;
    localparam int ONE        = 1 << FW;
    localparam int PW         = 2 * FW + 1;
    localparam int WW         = 3 * FW + 1;
    localparam int SW         = WW + CW;
    localparam int NCORNER    = 8;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int POSW       = CW + GW - 1;
    localparam int TW         = $clog2(MAX_GRID * MAX_GRID);

    localparam logic [GW-1:0] GRID_RESET = GW'(9);
    localparam logic          FUNC_WRITE = 1'b0;
    localparam logic          FUNC_PIXEL = 1'b1;

    typedef logic [CW-1:0] chan_t;
    typedef logic [3*CW-1:0] rgb_t;

    typedef struct packed {
        logic [GW-1:0] lo;
        logic [CW-1:0] fr;
    } axis_t;

    typedef struct packed {
        logic                          pixel;
        logic [NCORNER-1:0][AW-1:0]    addr;
        logic [NCORNER-1:0][WW-1:0]    wgt;
        rgb_t                          data;
    } job_t;

    function automatic logic [GW-1:0] eff_grid(input logic [GW-1:0] g);
        logic [GW-1:0] r;
        r = g;
        if (r < GW'(2))
            r = GW'(2);
        if (r > GW'(MAX_GRID))
            r = GW'(MAX_GRID);
        return r;
    endfunction

    function automatic axis_t axis_calc(input chan_t val, input logic [GW-1:0] g);
        chan_t           vc;
        logic [POSW-1:0] pos;
        logic [GW-1:0]   c;
        axis_t           a;
        vc  = (val > CW'(ONE)) ? CW'(ONE) : val;
        pos = POSW'(vc) * POSW'(g - GW'(1));
        c   = GW'(pos >> FW);
        if (c > g - GW'(2))
            c = g - GW'(2);
        a.lo = c;
        a.fr = CW'(pos - {c, {FW{1'b0}}});
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lut3d_ifs.sv =====
// ----------------------------------------------------------------------------
// lut3d channel interfaces
// Valid/ready channels for configuration, input items and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lut3d_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lut3d_pkg::GW-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lut3d_pix_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [lut3d_pkg::AW-1:0]   cell_address;
    lut3d_pkg::chan_t           red_value;
    lut3d_pkg::chan_t           green_value;
    lut3d_pkg::chan_t           blue_value;
    modport source (output valid, output func, output cell_address, output red_value,
                    output green_value, output blue_value, input ready);
    modport sink   (input valid, input func, input cell_address, input red_value,
                    input green_value, input blue_value, output ready);
endinterface

interface lut3d_res_if;
    logic                       valid;
    logic                       ready;
    lut3d_pkg::chan_t           out_red;
    lut3d_pkg::chan_t           out_green;
    lut3d_pkg::chan_t           out_blue;
    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/lut3d_trilinear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// lut3d_trilinear_interpolator_unit: 3D color-cube lookup with trilinear mix
// Top level joining the front, the job queue and the back.
// ----------------------------------------------------------------------------
// Usage:
//   cfg       : write grid_points (points per axis, clamped to 2..17).
//               Always ready; write only while the block is idle.
//   pixel_in  : func 0 stores {red,green,blue} at cell_address; func 1
//               interpolates a pixel. One transfer per cycle when the result
//               side keeps up.
//   result_out: one transfer per pixel, in input order; table writes make
//               none.
//   Path from input transfer to result valid: the input register, two front
//   stages, one queue slot, one table read, three sum stages and the result
//   register.
//   Throughput: one item per cycle while the result side keeps up, set by the
//   eight table copies that give all corners of a pixel in one read.
//   A stalled receiver holds the result register and the back stages; the
//   front keeps accepting until the four-entry queue fills, then drops
//   pixel_in.ready.
//   Reset clears all valid state and sets the grid to 9. Table contents are
//   undefined until written; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_trilinear_interpolator_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    lut3d_cfg_if.sink       cfg,
    lut3d_pix_if.sink       pixel_in,
    lut3d_res_if.source     result_out
);

    logic            push, pop, q_full, q_empty;
    lut3d_pkg::job_t job_f, job_b;

    assign cfg.ready = 1'b1;

    // classify items, compute corners and weights
    lut3d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .in_valid     (pixel_in.valid),
        .in_ready     (pixel_in.ready),
        .func         (pixel_in.func),
        .cell_address (pixel_in.cell_address),
        .red_value    (pixel_in.red_value),
        .green_value  (pixel_in.green_value),
        .blue_value   (pixel_in.blue_value),
        .q_full       (q_full),
        .push         (push),
        .job          (job_f)
    );

    // decouple the two sides
    lut3d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_f),
        .full    (q_full),
        .pop     (pop),
        .job_out (job_b),
        .empty   (q_empty)
    );

    // store entries, fetch corners, sum and round
    lut3d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_b),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_red   (result_out.out_red),
        .out_green (result_out.out_green),
        .out_blue  (result_out.out_blue)
    );

endmodule

`default_nettype wire

// ===== rtl/lut3d_front.sv =====
// ----------------------------------------------------------------------------
// lut3d_front: item intake and address/weight generation
// Holds the grid register, classifies items and turns pixels into eight
// corner addresses and eight corner weights over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [lut3d_pkg::GW-1:0]    cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        func,
    input  wire logic [lut3d_pkg::AW-1:0]    cell_address,
    input  wire lut3d_pkg::chan_t            red_value,
    input  wire lut3d_pkg::chan_t            green_value,
    input  wire lut3d_pkg::chan_t            blue_value,
    input  wire logic                        q_full,
    output logic                             push,
    output lut3d_pkg::job_t                  job
);

    localparam int AW = lut3d_pkg::AW;
    localparam int GW = lut3d_pkg::GW;
    localparam int CW = lut3d_pkg::CW;
    localparam int PW = lut3d_pkg::PW;
    localparam int WW = lut3d_pkg::WW;
    localparam int TW = lut3d_pkg::TW;

    logic [GW-1:0]   grid_reg;
    logic [GW-1:0]   geff;
    logic [TW-1:0]   g2;
    logic            adv;
    lut3d_pkg::axis_t ax_r, ax_g, ax_b;

    // stage 0: corners and fractions
    logic            f0_valid_reg, f0_pixel_reg;
    logic [AW-1:0]   f0_addr_reg;
    lut3d_pkg::rgb_t f0_data_reg;
    logic [GW-1:0]   f0_r0_reg, f0_g0_reg, f0_b0_reg;
    logic [CW-1:0]   f0_wr_reg [2];
    logic [CW-1:0]   f0_wg_reg [2];
    logic [CW-1:0]   f0_wb_reg [2];

    // stage 1: partial address and red-green weights
    logic            f1_valid_reg, f1_pixel_reg;
    logic [AW-1:0]   f1_addr_reg;
    lut3d_pkg::rgb_t f1_data_reg;
    logic [TW-1:0]   f1_t_reg;
    logic [GW-1:0]   f1_b0_reg;
    logic [PW-1:0]   f1_wrg_reg [4];
    logic [CW-1:0]   f1_wb_reg [2];

    // stage 2: base address and full weights
    logic            f2_valid_reg, f2_pixel_reg;
    logic [AW-1:0]   f2_addr_reg;
    lut3d_pkg::rgb_t f2_data_reg;
    logic [AW-1:0]   f2_base_reg;
    logic [WW-1:0]   f2_w_reg [8];

    assign geff     = lut3d_pkg::eff_grid(grid_reg);
    assign g2       = TW'(geff) * TW'(geff);
    assign adv      = !q_full;
    assign in_ready = adv;
    assign push     = adv && f2_valid_reg;

    assign ax_r = lut3d_pkg::axis_calc(red_value, geff);
    assign ax_g = lut3d_pkg::axis_calc(green_value, geff);
    assign ax_b = lut3d_pkg::axis_calc(blue_value, geff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg     <= lut3d_pkg::GRID_RESET;
            f0_valid_reg <= 1'b0;
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                grid_reg <= cfg_data;
            if (adv)
            begin
                f0_valid_reg <= in_valid;
                f1_valid_reg <= f0_valid_reg;
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_pixel_reg <= (func == lut3d_pkg::FUNC_PIXEL);
            f0_addr_reg  <= cell_address;
            f0_data_reg  <= {red_value, green_value, blue_value};
            f0_r0_reg    <= ax_r.lo;
            f0_g0_reg    <= ax_g.lo;
            f0_b0_reg    <= ax_b.lo;
            f0_wr_reg[0] <= CW'(lut3d_pkg::ONE) - ax_r.fr;
            f0_wr_reg[1] <= ax_r.fr;
            f0_wg_reg[0] <= CW'(lut3d_pkg::ONE) - ax_g.fr;
            f0_wg_reg[1] <= ax_g.fr;
            f0_wb_reg[0] <= CW'(lut3d_pkg::ONE) - ax_b.fr;
            f0_wb_reg[1] <= ax_b.fr;

            f1_pixel_reg <= f0_pixel_reg;
            f1_addr_reg  <= f0_addr_reg;
            f1_data_reg  <= f0_data_reg;
            f1_t_reg     <= TW'(f0_r0_reg) * TW'(geff) + TW'(f0_g0_reg);
            f1_b0_reg    <= f0_b0_reg;
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 2; j++)
                    f1_wrg_reg[i*2+j] <= PW'(f0_wr_reg[i]) * PW'(f0_wg_reg[j]);
            f1_wb_reg[0] <= f0_wb_reg[0];
            f1_wb_reg[1] <= f0_wb_reg[1];

            f2_pixel_reg <= f1_pixel_reg;
            f2_addr_reg  <= f1_addr_reg;
            f2_data_reg  <= f1_data_reg;
            f2_base_reg  <= AW'(f1_t_reg) * AW'(geff) + AW'(f1_b0_reg);
            for (int m = 0; m < 4; m++)
                for (int k = 0; k < 2; k++)
                    f2_w_reg[m*2+k] <= WW'(f1_wrg_reg[m]) * WW'(f1_wb_reg[k]);
        end
    end

    // corner n = {ri, gi, bi}: offset ri*G*G + gi*G + bi
    always_comb
    begin
        job.pixel = f2_pixel_reg;
        job.data  = f2_data_reg;
        for (int n = 0; n < 8; n++)
        begin
            job.wgt[n] = f2_w_reg[n];
            if (f2_pixel_reg)
                job.addr[n] = f2_base_reg + (n[2] ? AW'(g2) : AW'(0))
                            + (n[1] ? AW'(geff) : AW'(0)) + AW'(n[0]);
            else
                job.addr[n] = f2_addr_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lut3d_queue.sv =====
// ----------------------------------------------------------------------------
// lut3d_queue: job queue between front and back
// Small register FIFO that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lut3d_pkg::job_t    job_in,
    output logic                    full,
    input  wire logic               pop,
    output lut3d_pkg::job_t         job_out,
    output logic                    empty
);

    localparam int QAW = lut3d_pkg::QAW;

    lut3d_pkg::job_t slot_reg [lut3d_pkg::QDEPTH];
    logic [QAW-1:0]  wp_reg, rp_reg;
    logic [QAW:0]    cnt_reg;

    assign full    = (cnt_reg == (QAW+1)'(lut3d_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign job_out = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= job_in;
    end

endmodule

`default_nettype wire

// ===== rtl/lut3d_back.sv =====
// ----------------------------------------------------------------------------
// lut3d_back: table banks and weighted-sum datapath
// Eight copies of the table serve the eight corners in the same read; products,
// an adder tree and rounding feed the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lut3d_pkg::job_t    job,
    input  wire logic               q_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lut3d_pkg::chan_t        out_red,
    output lut3d_pkg::chan_t        out_green,
    output lut3d_pkg::chan_t        out_blue
);

    localparam int CW = lut3d_pkg::CW;
    localparam int WW = lut3d_pkg::WW;
    localparam int SW = lut3d_pkg::SW;
    localparam int FW = lut3d_pkg::FW;

    logic            adv, we, re;
    logic            s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, o_valid_reg;
    lut3d_pkg::rgb_t rd_reg [8];
    logic [WW-1:0]   s0_w_reg [8];
    logic [SW-1:0]   s1_p_reg [3][8];
    logic [SW-1:0]   s2_s_reg [3][4];
    logic [SW-1:0]   s3_s_reg [3][2];
    lut3d_pkg::chan_t o_reg [3];
    logic [SW-1:0]   acc [3];

    assign adv = !o_valid_reg || out_ready;
    assign pop = adv && !q_empty;
    assign we  = pop && !job.pixel && (job.addr[0] < lut3d_pkg::AW'(lut3d_pkg::CELLS));
    assign re  = pop && job.pixel;

    for (genvar n = 0; n < 8; n++)
    begin : g_bank
        lut3d_pkg::rgb_t mem [lut3d_pkg::CELLS];
        always_ff @(posedge clk)
        begin
            if (we)
                mem[job.addr[0]] <= job.data;
            if (re)
                rd_reg[n] <= mem[job.addr[n]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= re;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            o_valid_reg  <= s3_valid_reg;
        end
    end

    // round half up: add half an LSB of the 2^30 scale
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            acc[c] = s3_s_reg[c][0] + s3_s_reg[c][1] + SW'(1 << (3*FW - 1));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (re)
                for (int n = 0; n < 8; n++)
                    s0_w_reg[n] <= job.wgt[n];
            for (int c = 0; c < 3; c++)
            begin
                for (int n = 0; n < 8; n++)
                    s1_p_reg[c][n] <= SW'(rd_reg[n][(2-c)*CW +: CW]) * SW'(s0_w_reg[n]);
                for (int m = 0; m < 4; m++)
                    s2_s_reg[c][m] <= s1_p_reg[c][2*m] + s1_p_reg[c][2*m+1];
                for (int m = 0; m < 2; m++)
                    s3_s_reg[c][m] <= s2_s_reg[c][2*m] + s2_s_reg[c][2*m+1];
                o_reg[c] <= acc[c][3*FW +: CW];
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_red   = o_reg[0];
    assign out_green = o_reg[1];
    assign out_blue  = o_reg[2];

endmodule

`default_nettype wire

// ===== rtl/lut3d_chk.sv =====
// ----------------------------------------------------------------------------
// lut3d_chk: port-level checks
// Watches the top-level channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module lut3d_chk (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic                      in_ready,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic [3*lut3d_pkg::CW-1:0] out_data
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without result stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind lut3d_trilinear_interpolator_unit lut3d_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready),
    .in_ready  (pixel_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  ({result_out.out_red, result_out.out_green, result_out.out_blue})
);

`default_nettype wire
